// ===== hw/rtl/hsl_pkg.sv =====
`default_nettype none
package hsl_pkg;

  localparam int CellCount = 8;

  localparam logic [1:0] MODE_GAIN_D = 2'd0;
  localparam logic [1:0] MODE_GAIN_P = 2'd1;
  localparam logic [1:0] MODE_SHRINK = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [2:0][17:0]  rem;
    logic [15:0]       dsh;
    logic [2:0][7:0]   quo;
    logic [2:0]        sat;
  } div_beat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hsl_div_cell.sv =====
`default_nettype none
module hsl_div_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    en,
  input  wire hsl_pkg::div_beat_t din,
  output hsl_pkg::div_beat_t     dout
);

  hsl_pkg::div_beat_t nxt;

  always_comb begin
    nxt = din;
    nxt.dsh = {1'b0, din.dsh[15:1]};
    for (int k = 0; k < 3; k++) begin
      if (din.rem[k] >= {2'b00, din.dsh}) begin
        nxt.rem[k] = din.rem[k] - {2'b00, din.dsh};
        nxt.quo[k] = {din.quo[k][6:0], 1'b1};
      end else begin
        nxt.quo[k] = {din.quo[k][6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= nxt.valid;
    end
    if (en) begin
      dout.rem <= nxt.rem;
      dout.dsh <= nxt.dsh;
      dout.quo <= nxt.quo;
      dout.sat <= nxt.sat;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hsl_saturation_adjust.sv =====
// pipeline: 4 front stages, then 8 divider cells, from input beat to output beat
// throughput: one pixel per cycle while the output is not stalled; the divider is a row of cells, one quotient bit each
// the whole pipeline holds while an output beat waits and m_axis_tready is low
// reset (rst, synchronous): clears all stage valid bits and sets the percent to 0
`default_nettype none
module hsl_saturation_adjust (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [7:0]  cfg_data,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [23:0] s_axis_tdata,   // chan_a, chan_b, chan_c
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [23:0] m_axis_tdata   // out_a, out_b, out_c
);

  logic signed [7:0] pct;
  logic en;

  logic            v1, v2, v3;
  logic [2:0][7:0] c1, c2;
  logic [7:0]      d1, d2, den1, den2;
  logic [8:0]      sum1, sum2;
  logic            grey1, grey2;
  logic [1:0]      mode2;
  logic signed [2:0][20:0] num3;
  logic [8:0]      div3;

  hsl_pkg::div_beat_t pipe [hsl_pkg::CellCount+1];

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= 8'sd0;
    end else if (cfg_we) begin
      pct <= cfg_data;
    end
  end

  // stage 1: max, min, spread, sum, grey flag and denominator
  logic [7:0] mx, mn;
  always_comb begin
    mx = s_axis_tdata[7:0];
    mn = s_axis_tdata[7:0];
    for (int k = 1; k < 3; k++) begin
      if (s_axis_tdata[8*k +: 8] > mx) mx = s_axis_tdata[8*k +: 8];
      if (s_axis_tdata[8*k +: 8] < mn) mn = s_axis_tdata[8*k +: 8];
    end
  end

  logic [8:0] sum_in;
  assign sum_in = {1'b0, mx} + {1'b0, mn};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid; v2 <= v1; v3 <= v2;
    end
    if (en) begin
      c1    <= s_axis_tdata;
      d1    <= mx - mn;
      sum1  <= sum_in;
      grey1 <= (mx == mn);
      den1  <= (sum_in < 9'd255) ? sum_in[7:0] : 8'(10'd510 - {1'b0, sum_in});
    end
  end

  // stage 2: choose the gain
  logic [16:0] lhs, rhs;
  assign lhs = 17'(pct[6:0]) * 17'(den1) + 17'(7'd100) * 17'(d1);
  assign rhs = 17'(7'd100) * 17'(den1);

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c1; d2 <= d1; sum2 <= sum1; den2 <= den1; grey2 <= grey1;
      if (pct[7]) begin
        mode2 <= hsl_pkg::MODE_SHRINK;
      end else if (lhs >= rhs) begin
        mode2 <= hsl_pkg::MODE_GAIN_D;
      end else begin
        mode2 <= hsl_pkg::MODE_GAIN_P;
      end
    end
  end

  // stage 3: numerators and divisor
  logic [9:0]  f1 [3];
  logic [8:0]  f2;
  logic signed [9:0] g;
  logic [8:0]  div_sel;
  logic signed [10:0] t [3];
  logic [18:0] a_u [3];
  logic signed [20:0] b_s [3];
  logic [6:0] p_lo;
  assign p_lo = pct[6:0];

  always_comb begin
    f2 = 9'd0;
    g = 10'sd0;
    div_sel = 9'd1;
    unique case (mode2)
      hsl_pkg::MODE_GAIN_D: begin
        f2 = {1'b0, d2};
        g = $signed({2'b00, den2 - d2});
        div_sel = {d2, 1'b0};
      end
      hsl_pkg::MODE_GAIN_P: begin
        f2 = {2'b00, 7'(7'd100 - p_lo)};
        g = $signed({3'b000, p_lo});
        div_sel = {1'b0, 7'(7'd100 - p_lo), 1'b0};
      end
      hsl_pkg::MODE_SHRINK: begin
        f2 = 9'd100;
        g = 10'sd100 + 10'($signed(pct));
        div_sel = 9'd200;
      end
      default: begin
        f2 = 9'd0;
        g = 10'sd0;
        div_sel = 9'd1;
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      t[k] = $signed({2'b00, c2[k], 1'b0}) - $signed({2'b00, sum2});
      f1[k] = (mode2 == hsl_pkg::MODE_SHRINK) ? {1'b0, sum2} : {1'b0, c2[k], 1'b0};
      a_u[k] = f1[k] * f2;
      b_s[k] = t[k] * g;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div3 <= grey2 ? 9'd1 : div_sel;
      for (int k = 0; k < 3; k++) begin
        num3[k] <= grey2 ? $signed({13'd0, c2[k]}) : ($signed({2'b00, a_u[k]}) + b_s[k]);
      end
    end
  end

  // stage 4: sign and overflow check, load the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (en) begin
      pipe[0].valid <= v3;
    end
    if (en) begin
      pipe[0].dsh <= {div3, 7'd0};
      for (int k = 0; k < 3; k++) begin
        pipe[0].quo[k] <= 8'd0;
        if (num3[k][20]) begin
          pipe[0].rem[k] <= 18'd0;
          pipe[0].sat[k] <= 1'b0;
        end else begin
          pipe[0].rem[k] <= num3[k][17:0];
          pipe[0].sat[k] <= (num3[k][19:0] >= {3'd0, div3, 8'd0});
        end
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < hsl_pkg::CellCount; gi++) begin : g_cell
      hsl_div_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (en),
        .din  (pipe[gi]),
        .dout (pipe[gi+1])
      );
    end
  endgenerate

  assign m_axis_tvalid = pipe[hsl_pkg::CellCount].valid;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_axis_tdata[8*k +: 8] = pipe[hsl_pkg::CellCount].sat[k] ? 8'd255
                                 : pipe[hsl_pkg::CellCount].quo[k];
    end
  end

  a_s1_s2: assert property (@(posedge clk) disable iff (rst) (v1 && en) |=> v2)
    else $error("stage 2 lost a beat");
  a_s3_div: assert property (@(posedge clk) disable iff (rst) (v3 && en) |=> pipe[0].valid)
    else $error("divider load lost a beat");
  a_hold: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(v3))
    else $error("front stage moved during stall");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
